// ----- hw/rtl/mpk_pkg.sv -----
// shared constants, types and the per-letter coding rules for the phonetic key block
// no dependencies; imported by mpk_store, mpk_coder and metaphone_phonetic_key
`default_nettype none
package mpk_pkg;

	localparam int MAX_LETTERS = 32;
	localparam int AW = $clog2(MAX_LETTERS);
	localparam int CW = $clog2(MAX_LETTERS + 1);
	localparam int SW = $clog2(MAX_LETTERS + 5);
	localparam int CODE_MAX = 4;
	localparam int CODE_SLOTS = 5;

	localparam logic [7:0] NO_LETTER = 8'h00;
	localparam logic [7:0] ZERO_CHAR = 8'h30;

	// coder start request from the load side
	typedef struct packed {
		logic          go;
		logic [CW-1:0] count;
		logic          skip_en;
		logic          skip_one;
	} start_t;

	// finished code toward the output register
	typedef struct packed {
		logic             done;
		logic [2:0]       count;
		logic [4:0][7:0]  code;
	} done_t;

	// characters produced by one letter
	typedef struct packed {
		logic [1:0] num;
		logic [7:0] c1;
		logic [7:0] c2;
	} rule_t;

	function automatic logic is_vowel(input logic [7:0] x);
		return x == "A" || x == "E" || x == "I" || x == "O" || x == "U";
	endfunction

	function automatic logic is_eiy(input logic [7:0] x);
		return x == "E" || x == "I" || x == "Y";
	endfunction

	function automatic logic is_csptg(input logic [7:0] x);
		return x == "C" || x == "S" || x == "P" || x == "T" || x == "G";
	endfunction

	// code for letter c with two letters behind and four ahead (zero = no letter)
	function automatic rule_t code_rule(
		input logic [7:0] pp, input logic [7:0] pv, input logic [7:0] c,
		input logic [7:0] nx, input logic [7:0] n2, input logic [7:0] n3,
		input logic [7:0] n4);
		rule_t r;
		logic  s1;
		logic  s2;
		logic  s3;
		r.num = 2'd0;
		r.c1  = NO_LETTER;
		r.c2  = NO_LETTER;
		s1 = nx == "H" && n2 != NO_LETTER && !is_vowel(n2);
		s2 = pv != NO_LETTER && nx == "N" &&
			(n2 == NO_LETTER || (n2 == "E" && n3 == "D" && n4 == NO_LETTER));
		s3 = pv == "D" && is_eiy(nx);
		if (c != "C" && pp != NO_LETTER && pv == c) begin
			r.num = 2'd0;
		end else begin
			case (c)
				"A", "E", "I", "O", "U": begin
					if (pv == NO_LETTER) begin
						r.num = 2'd1; r.c1 = c;
					end
				end
				"B": begin
					if (!(nx == NO_LETTER && pv == "M")) begin
						r.num = 2'd1; r.c1 = "B";
					end
				end
				"C": begin
					if (pv == "S" && is_eiy(nx)) begin
						r.num = 2'd0;
					end else if (nx == "I" && n2 == "A") begin
						r.num = 2'd1; r.c1 = "S";
					end else if (is_eiy(nx)) begin
						r.num = 2'd1; r.c1 = "S";
					end else if (nx == "H" && pv == "S") begin
						r.num = 2'd1; r.c1 = "K";
					end else if (nx == "H") begin
						r.num = 2'd1;
						r.c1 = (pv == NO_LETTER && n2 != NO_LETTER && !is_vowel(n2)) ?
							8'("K") : 8'("X");
					end else begin
						r.num = 2'd1; r.c1 = "K";
					end
				end
				"D": begin
					r.num = 2'd1;
					r.c1 = (nx == "G" && is_eiy(n2)) ? 8'("J") : 8'("T");
				end
				"G": begin
					if (!(s1 || s2 || s3)) begin
						r.num = 2'd1;
						r.c1 = (is_eiy(nx) && pv != "G") ? 8'("J") : 8'("K");
					end
				end
				"H": begin
					if (!(nx == NO_LETTER || is_csptg(pv)) && is_vowel(nx)) begin
						r.num = 2'd1; r.c1 = "H";
					end
				end
				"F", "J", "L", "M", "N", "R": begin
					r.num = 2'd1; r.c1 = c;
				end
				"K": begin
					if (pv != "C") begin
						r.num = 2'd1; r.c1 = "K";
					end
				end
				"P": begin
					r.num = 2'd1;
					r.c1 = (nx == "H") ? 8'("F") : 8'("P");
				end
				"Q": begin
					r.num = 2'd1; r.c1 = "K";
				end
				"S": begin
					r.num = 2'd1;
					if (pv != NO_LETTER && nx == "I" && (n2 == "O" || n2 == "A")) begin
						r.c1 = "X";
					end else begin
						r.c1 = (nx == "H") ? 8'("X") : 8'("S");
					end
				end
				"T": begin
					if (pv != NO_LETTER && nx == "I" && (n2 == "O" || n2 == "A")) begin
						r.num = 2'd1; r.c1 = "X";
					end else if (nx == "H") begin
						if (pv != "T") begin
							r.num = 2'd1; r.c1 = ZERO_CHAR;
						end
					end else if (!(nx == "C" && n2 == "H")) begin
						r.num = 2'd1; r.c1 = "T";
					end
				end
				"V": begin
					r.num = 2'd1; r.c1 = "F";
				end
				"W", "Y": begin
					if (is_vowel(nx)) begin
						r.num = 2'd1; r.c1 = c;
					end
				end
				"X": begin
					r.num = 2'd2; r.c1 = "K"; r.c2 = "S";
				end
				"Z": begin
					r.num = 2'd1; r.c1 = "S";
				end
				default: begin
					r.num = 2'd0;
				end
			endcase
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mpk_store.sv -----
// letter store: one write port, one read port with registered read data
// depends on mpk_pkg for depth and address width
`default_nettype none
module mpk_store (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [mpk_pkg::AW-1:0] wr_addr,
	input  wire logic [4:0]           wr_data,
	input  wire logic                 rd_en,
	input  wire logic [mpk_pkg::AW-1:0] rd_addr,
	output logic      [4:0]           rd_data
);
	import mpk_pkg::*;

	logic [4:0] mem [MAX_LETTERS];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, read data registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/mpk_coder.sv -----
// coding pass: streams stored letters through a seven-letter window and builds the code
// depends on mpk_pkg (types, rules); drives the read port of mpk_store
`default_nettype none
module mpk_coder (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mpk_pkg::start_t        start,
	input  wire logic                   ack,
	output logic                        rd_en,
	output logic [mpk_pkg::AW-1:0]      rd_addr,
	input  wire logic [4:0]             rd_data,
	output mpk_pkg::done_t              result
);
	import mpk_pkg::*;

	typedef enum logic [1:0] {IDLE, FETCH, DRAIN, DONE} state_t;

	state_t        state_q;
	logic [SW-1:0] src_q;
	logic [CW-1:0] len_q;
	logic          skip_en_q;
	logic          skip_one_q;
	logic          drain_q;
	logic          push_s1;
	logic          pad_s1;
	logic          first_q;
	logic          ev_q;
	logic [7:0]    win_q [7];
	logic [2:0]    k_q;
	logic [7:0]    code_q [CODE_SLOTS];
	logic          skip_now;
	logic [SW-1:0] last_src;
	logic [7:0]    letter;
	rule_t         rule;
	logic [2:0]    k_next;

	assign skip_now = skip_en_q && (src_q == (skip_one_q ? SW'(1) : SW'(0)));
	assign last_src = SW'(len_q) + SW'(3);
	assign rd_en    = (state_q == FETCH);
	assign rd_addr  = src_q[AW-1:0];
	assign letter   = 8'("A") + {3'd0, rd_data};
	assign rule     = code_rule(win_q[0], win_q[1], win_q[2], win_q[3],
		win_q[4], win_q[5], win_q[6]);
	assign k_next   = k_q + 3'd1;

	// sequencer: fetch letters and pads, drain, hold result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			src_q      <= '0;
			len_q      <= '0;
			skip_en_q  <= 1'b0;
			skip_one_q <= 1'b0;
			drain_q    <= 1'b0;
			push_s1    <= 1'b0;
			pad_s1     <= 1'b0;
		end else begin
			push_s1 <= 1'b0;
			case (state_q)
				IDLE: begin
					if (start.go) begin
						state_q    <= FETCH;
						src_q      <= '0;
						len_q      <= start.count;
						skip_en_q  <= start.skip_en;
						skip_one_q <= start.skip_one;
					end
				end
				FETCH: begin
					push_s1 <= !skip_now;
					pad_s1  <= (src_q >= SW'(len_q));
					src_q   <= src_q + SW'(1);
					if (src_q == last_src) begin
						state_q <= DRAIN;
						drain_q <= 1'b0;
					end
				end
				DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (ack) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// window shift as read data arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
			ev_q    <= 1'b0;
		end else begin
			ev_q <= push_s1;
			if (state_q == IDLE && start.go) begin
				first_q <= 1'b1;
			end else if (push_s1 && !pad_s1) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && start.go) begin
			for (int i = 0; i < 7; i++) begin
				win_q[i] <= NO_LETTER;
			end
		end else if (push_s1) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= win_q[i+1];
			end
			if (pad_s1) begin
				win_q[6] <= NO_LETTER;
			end else if (first_q && letter == "X") begin
				win_q[6] <= "S";
			end else begin
				win_q[6] <= letter;
			end
		end
	end

	// code build: one window position per cycle while fewer than four characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (state_q == IDLE && start.go) begin
			k_q <= '0;
		end else if (ev_q && win_q[2] != NO_LETTER && k_q < 3'(CODE_MAX)) begin
			k_q <= k_q + {1'b0, rule.num};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && start.go) begin
			for (int i = 0; i < CODE_SLOTS; i++) begin
				code_q[i] <= NO_LETTER;
			end
		end else if (ev_q && win_q[2] != NO_LETTER && k_q < 3'(CODE_MAX)) begin
			if (rule.num != 2'd0) begin
				code_q[k_q] <= rule.c1;
			end
			if (rule.num == 2'd2) begin
				code_q[k_next] <= rule.c2;
			end
		end
	end

	assign result.done  = (state_q == DONE);
	assign result.count = k_q;
	always_comb begin
		for (int i = 0; i < CODE_SLOTS; i++) begin
			result.code[i] = code_q[i];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/metaphone_phonetic_key.sv -----
// Phonetic key block: one character per transaction on the input stream, letters are
// kept (folded to upper case) until the transaction with tlast; s_axis_tready stays
// high while a word loads. After the last character the block deasserts s_axis_tready
// and runs the coding pass over the letter store, one memory read per cycle: L + 4 reads
// for L stored letters. A start register comes before the reads, and after a pipeline
// drain the code is handed off into the output register once that register is free.
// The result transaction carries up to five code characters, their number and a flag
// for letters dropped past the 32-entry store. A finished code waits in an output
// register; s_axis_tready stays low from tlast until the code has moved into that
// register, so a stalled result sink also stalls the next word.
// depends on mpk_pkg, mpk_store, mpk_coder
`default_nettype none
module metaphone_phonetic_key (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
	input  wire logic        s_axis_tlast,   // word_end
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // code_a, code_b, code_c, code_d, code_e, code_count
	output logic             m_axis_tuser    // word_overflow
);
	import mpk_pkg::*;

	logic          in_acc;
	logic          is_upper;
	logic          is_lower;
	logic [7:0]    up_ch;
	logic          is_letter;
	logic [4:0]    letter_idx;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          busy_q;
	logic          start_q;
	logic [7:0]    a_q;
	logic [7:0]    b_q;
	logic          drop;
	logic          wh;
	logic          wr_en;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [4:0]    rd_data;
	logic          ack;
	logic          out_valid_q;
	logic [39:0]   code_out_q;
	logic [2:0]    count_out_q;
	logic          ovf_out_q;
	start_t        start;
	done_t         result;

	// letter fold
	assign in_acc     = s_axis_tvalid && s_axis_tready;
	assign is_upper   = s_axis_tdata >= 8'("A") && s_axis_tdata <= 8'("Z");
	assign is_lower   = s_axis_tdata >= 8'("a") && s_axis_tdata <= 8'("z");
	assign up_ch      = is_lower ? (s_axis_tdata - 8'd32) : s_axis_tdata;
	assign is_letter  = is_upper || is_lower;
	assign letter_idx = 5'(up_ch - 8'("A"));
	assign wr_en      = in_acc && is_letter && (cnt_q < CW'(MAX_LETTERS));
	assign s_axis_tready = !busy_q;

	// initial-letter rules decided from the first two letters
	assign drop = cnt_q >= CW'(2) && (
		(a_q == "P" && b_q == "N") || (a_q == "A" && b_q == "E") ||
		(a_q == "K" && b_q == "N") || (a_q == "G" && b_q == "N") ||
		(a_q == "W" && b_q == "R"));
	assign wh = cnt_q >= CW'(2) && a_q == "W" && b_q == "H";

	assign start.go       = start_q;
	assign start.count    = cnt_q;
	assign start.skip_en  = drop || wh;
	assign start.skip_one = wh;

	assign ack = result.done && (!out_valid_q || m_axis_tready);

	// load control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			busy_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (ack) begin
				cnt_q  <= '0;
				ovf_q  <= 1'b0;
				busy_q <= 1'b0;
			end else if (in_acc) begin
				if (wr_en) begin
					cnt_q <= cnt_q + CW'(1);
				end else if (is_letter) begin
					ovf_q <= 1'b1;
				end
				if (s_axis_tlast) begin
					busy_q  <= 1'b1;
					start_q <= 1'b1;
				end
			end
		end
	end

	// first two letters kept aside for the initial rules
	always_ff @(posedge clk) begin
		if (wr_en && cnt_q == CW'(0)) begin
			a_q <= up_ch;
		end
		if (wr_en && cnt_q == CW'(1)) begin
			b_q <= up_ch;
		end
	end

	mpk_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (letter_idx),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mpk_coder u_coder (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.ack     (ack),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.result  (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ack) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			code_out_q  <= result.code;
			count_out_q <= result.count;
			ovf_out_q   <= ovf_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, count_out_q, code_out_q};
	assign m_axis_tuser  = ovf_out_q;

	// checks
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result.done |-> busy_q) else $error("coder done while no word is pending");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_LETTERS)) else $error("letter count past store depth");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> count_out_q <= 3'd5) else $error("code count above five");
	a_ack_free: assert property (@(posedge clk) disable iff (!arst_n)
		ack |=> !busy_q && m_axis_tvalid) else $error("result hand-off incomplete");

endmodule
`default_nettype wire
